@@ hw/rtl/plb_pkg.sv @@
// plb_pkg: shared types and constants for the positional list buffer.
// Holds the request and response words, request and status codes and the
// controller-to-datapath command word. Depends on nothing.
package plb_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    // Request type codes
    localparam logic [2:0] REQ_INS_POS   = 3'd0;
    localparam logic [2:0] REQ_REM_POS   = 3'd1;
    localparam logic [2:0] REQ_INS_FRONT = 3'd2;
    localparam logic [2:0] REQ_INS_END   = 3'd3;
    localparam logic [2:0] REQ_REM_FRONT = 3'd4;
    localparam logic [2:0] REQ_REM_END   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [4:0]         position;
    } plb_req_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [4:0]         length;
    } plb_rsp_t;

    typedef struct packed {
        logic capture;  // latch the incoming request word
        logic commit;   // apply the latched request and load the response
    } plb_cmd_t;

endpackage

@@ hw/rtl/plb_ctrl.sv @@
// plb_ctrl: request sequencer for the positional list buffer.
// Depends on plb_pkg for the command word.
module plb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output plb_pkg::plb_cmd_t cmd
);
    import plb_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        cmd.capture = start && (state_reg == S_IDLE);
        cmd.commit  = (state_reg == S_EXEC);
        state_next  = state_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // execute the latched request, then present the response
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

@@ hw/rtl/plb_datapath.sv @@
// plb_datapath: row of shifting cells, entry count and response register.
// Depends on plb_pkg for request, response and command words.
module plb_datapath #(
    parameter int CAPACITY = plb_pkg::DEFAULT_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  plb_pkg::plb_cmd_t cmd,
    input  plb_pkg::plb_req_t req,
    output plb_pkg::plb_rsp_t rsp
);
    import plb_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (CW > 5) ? CW : 5;

    plb_req_t          req_reg;
    plb_rsp_t          rsp_reg;
    plb_rsp_t          rsp_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic signed [31:0] cell_reg [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];

    logic [PW-1:0] cnt_ext;
    logic [PW-1:0] tpos;
    logic          is_ins;
    logic          is_rem;
    logic [1:0]    status;
    logic          do_ins;
    logic          do_rem;
    logic [PW-1:0] new_cnt;

    always_comb
    begin
        cnt_ext = PW'(count_reg);
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        tpos    = '0;
        case (req_reg.req_type)
            REQ_INS_POS:
            begin
                is_ins = 1'b1;
                tpos   = PW'(req_reg.position);
            end
            REQ_REM_POS:
            begin
                is_rem = 1'b1;
                tpos   = PW'(req_reg.position);
            end
            REQ_INS_FRONT:
            begin
                is_ins = 1'b1;
            end
            REQ_INS_END:
            begin
                is_ins = 1'b1;
                tpos   = cnt_ext;
            end
            REQ_REM_FRONT:
            begin
                is_rem = 1'b1;
            end
            REQ_REM_END:
            begin
                is_rem = 1'b1;
                tpos   = (cnt_ext == '0) ? '0 : cnt_ext - PW'(1);
            end
            default:
            begin
                // unused codes leave the list alone
            end
        endcase

        status = ST_OK;
        if (is_ins)
        begin
            if (tpos > cnt_ext)
                status = ST_BAD_POS;
            else if (cnt_ext == PW'(CAPACITY))
                status = ST_FULL;
        end
        else if (is_rem)
        begin
            if (cnt_ext == '0)
                status = ST_EMPTY;
            else if (tpos >= cnt_ext)
                status = ST_BAD_POS;
        end

        do_ins  = is_ins && (status == ST_OK);
        do_rem  = is_rem && (status == ST_OK);
        new_cnt = cnt_ext;
        if (do_ins)
            new_cnt = cnt_ext + PW'(1);
        else if (do_rem)
            new_cnt = cnt_ext - PW'(1);
        count_next = CW'(new_cnt);

        rsp_next.status        = status;
        rsp_next.length        = new_cnt[4:0];
        rsp_next.removed_value = do_rem ? cell_reg[tpos[IW-1:0]] : '0;
    end

    // Each cell looks only at its neighbors: shift up for insert, down for remove
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins)
            begin
                if (PW'(i) == tpos)
                    cell_next[i] = req_reg.value;
                else if ((i > 0) && (PW'(i) > tpos))
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end
            else if (do_rem)
            begin
                if ((i < CAPACITY - 1) && (PW'(i) >= tpos))
                    cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= req;
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < CAPACITY; i++)
                cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    assign rsp = rsp_reg;

endmodule

@@ hw/rtl/positional_list_buffer_top.sv @@
// positional_list_buffer_top: ordered list of up to CAPACITY signed words.
// A request word taken when idle is latched, executed in the single execute
// state of the controller, and its response word is registered with done
// high. A new request is taken only when idle, not while one is executing.
// Reset clears the controller and the entry count; cell contents are kept.
// The receiver cannot stall; each response is shown for exactly one cycle.
module positional_list_buffer_top #(
    parameter int CAPACITY = plb_pkg::DEFAULT_CAPACITY
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  plb_pkg::plb_req_t req,
    output logic              done,
    output plb_pkg::plb_rsp_t rsp
);
    import plb_pkg::*;

    // Command word from the sequencer to the datapath
    plb_cmd_t cmd;

    // Sequencer: accept when idle, execute in a single state, strobe done.
    plb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Datapath: hold the request, shift the cells, register the response.
    plb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // An accepted request moves into execute at once.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    // Execute is followed directly by the response strobe, with busy low again.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute did not end in a response");

    // A response appears only after an execute cycle.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("response without a request");

    // A failed request reports a zero removed value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != ST_OK)) |-> (rsp.removed_value == '0))
        else $error("error response carries a value");
`endif

endmodule

@@ bench/tb_positional_list_buffer_top.sv @@
// tb_positional_list_buffer_top: self-checking bench for the positional list buffer.
// Drives request words through start/busy, predicts each response word from a
// shadow list and checks done/rsp; depends on plb_pkg and positional_list_buffer_top.
`timescale 1ns / 1ps

module tb_positional_list_buffer_top;

    import plb_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int RANDOM_WORDS   = 1900;
    localparam int WATCHDOG_LIMIT = 200;   // cycles with no word moving either way
    localparam int DRAIN_CYCLES   = 8;     // wait after the last response before the verdict

    // Request codes the block does not define; it must answer them as no-ops.
    localparam logic [2:0] REQ_UNUSED_A = 3'd6;
    localparam logic [2:0] REQ_UNUSED_B = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_CHURN
    } traffic_mode_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    plb_req_t req   = '0;
    logic     done;
    plb_rsp_t rsp;

    // Request words not yet accepted; the head is the word on the req port.
    plb_req_t req_backlog_q[$];
    // Response words predicted at accept time, oldest first.
    plb_rsp_t pending_rsp_q[$];
    // Shadow copy of the list contents, front of the list at index 0.
    logic signed [31:0] shadow_list[$];

    int unsigned gen_len;          // list length as the stimulus generator sees it
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned idle_cycles;
    int unsigned mismatch_count;

    positional_list_buffer_top #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Hold reset from time zero, then release it once for the whole run.
    initial
    begin
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one request word to the shadow list and return the response word
    // the block must give for it. A failed request leaves the list untouched.
    task automatic list_op_response(input plb_req_t r, output plb_rsp_t e);
        int unsigned at;
        int unsigned len;
        len = shadow_list.size();
        e   = '0;
        case (r.req_type)
            REQ_INS_POS, REQ_INS_FRONT, REQ_INS_END:
            begin
                if (r.req_type == REQ_INS_POS)
                    at = 32'(r.position);
                else if (r.req_type == REQ_INS_FRONT)
                    at = 0;
                else
                    at = len;
                // A bad position wins over a full list.
                if (at > len)
                    e.status = ST_BAD_POS;
                else if (len >= CAPACITY)
                    e.status = ST_FULL;
                else
                begin
                    shadow_list.insert(at, r.value);
                    e.status = ST_OK;
                end
            end
            REQ_REM_POS, REQ_REM_FRONT, REQ_REM_END:
            begin
                if (r.req_type == REQ_REM_POS)
                    at = 32'(r.position);
                else if (r.req_type == REQ_REM_FRONT || len == 0)
                    at = 0;
                else
                    at = len - 1;
                // An empty list is reported whatever the position.
                if (len == 0)
                    e.status = ST_EMPTY;
                else if (at >= len)
                    e.status = ST_BAD_POS;
                else
                begin
                    e.removed_value = shadow_list[at];
                    shadow_list.delete(at);
                    e.status = ST_OK;
                end
            end
            default:
            begin
                // Unused codes: list unchanged, status ok, nothing removed.
            end
        endcase
        e.length = 5'(shadow_list.size());
    endtask

    // Queue one request word and advance the generator's view of the length,
    // so that later positions can be aimed inside the list.
    task automatic queue_word(input logic [2:0] kind, input logic signed [31:0] val,
                              input int unsigned pos);
        plb_req_t    w;
        int unsigned at;
        w.req_type = kind;
        w.value    = val;
        w.position = pos[4:0];
        req_backlog_q.push_back(w);
        case (kind)
            REQ_INS_POS, REQ_INS_FRONT, REQ_INS_END:
            begin
                at = (kind == REQ_INS_POS) ? 32'(pos[4:0]) :
                     (kind == REQ_INS_FRONT) ? 0 : gen_len;
                if (at <= gen_len && gen_len < CAPACITY)
                    gen_len++;
            end
            REQ_REM_POS, REQ_REM_FRONT, REQ_REM_END:
            begin
                at = (kind == REQ_REM_POS) ? 32'(pos[4:0]) :
                     (kind == REQ_REM_FRONT || gen_len == 0) ? 0 : gen_len - 1;
                if (gen_len > 0 && at < gen_len)
                    gen_len--;
            end
            default:
            begin
            end
        endcase
    endtask

    // Driver: at each edge take note of an accepted word, predict its
    // response, then present the next word in bursts with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        plb_rsp_t predicted;
        if (!rst_n)
        begin
            start      <= 1'b0;
            req        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                list_op_response(req, predicted);
                pending_rsp_q.push_back(predicted);
                void'(req_backlog_q.pop_front());
            end

            if (start && busy)
            begin
                // Hold the word until the block takes it.
            end
            else if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (req_backlog_q.size() != 0)
            begin
                start <= 1'b1;
                req   <= req_backlog_q[0];
                if (burst_left <= 1)
                begin
                    // Close the burst: pick the next burst and the gap after this word.
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each response word against the oldest prediction and
    // keep the watchdog's count of cycles in which nothing moved.
    always @(posedge clk)
    begin
        plb_rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response: removed=%0d status=%0d len=%0d",
                         $time, rsp.removed_value, rsp.status, rsp.length);
                mismatch_count++;
            end
            else
            begin
                want = pending_rsp_q.pop_front();
                if (rsp.removed_value !== want.removed_value)
                begin
                    $display("%0t: removed_value expected %0d actual %0d",
                             $time, want.removed_value, rsp.removed_value);
                    mismatch_count++;
                end
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.length !== want.length)
                begin
                    $display("%0t: length expected %0d actual %0d",
                             $time, want.length, rsp.length);
                    mismatch_count++;
                end
            end
        end

        if ((start && !busy) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus and end of run.
    initial
    begin
        traffic_mode_t      mode;
        int unsigned        words_made;
        int unsigned        pos;
        int unsigned        ins_pct;
        logic [2:0]         kind;
        logic signed [31:0] val;
        bit                 timed_out;

        gen_len        = 0;
        idle_cycles    = 0;
        mismatch_count = 0;
        timed_out      = 1'b0;

        // Directed part. Start with removals from an empty list, whatever the
        // position, a positional insert past the end of an empty list and both unused codes.
        queue_word(REQ_REM_FRONT, 32'sd0, 0);
        queue_word(REQ_REM_END, 32'sd0, 0);
        queue_word(REQ_REM_POS, 32'sd0, 31);
        queue_word(REQ_INS_POS, 32'sd7, 5);
        queue_word(REQ_UNUSED_A, VAL_MAX, 31);
        queue_word(REQ_UNUSED_B, VAL_MIN, 0);
        // Build a short list with the value extremes through every insert form.
        queue_word(REQ_INS_POS, VAL_MIN, 0);
        queue_word(REQ_INS_END, VAL_MAX, 0);
        queue_word(REQ_INS_FRONT, 32'sd0, 0);
        queue_word(REQ_INS_POS, -32'sd1, 3);
        queue_word(REQ_INS_POS, 32'sh5a5a_a5a5, 1);
        // Positional removes past the end of a nonempty list, then one inside it.
        queue_word(REQ_REM_POS, 32'sd0, 5);
        queue_word(REQ_REM_POS, 32'sd0, 31);
        queue_word(REQ_REM_POS, 32'sd0, 2);
        // Fill to capacity, then try positional and front inserts on the full list;
        // the bad position must be reported ahead of the full list.
        while (gen_len < CAPACITY)
            queue_word(REQ_INS_END, $urandom, 0);
        queue_word(REQ_INS_POS, 32'sd1, CAPACITY);
        queue_word(REQ_INS_POS, 32'sd2, CAPACITY + 1);
        queue_word(REQ_INS_FRONT, 32'sd3, 0);

        // Random part: phases that fill, drain or churn the list, with most
        // positions aimed inside it and some anywhere in the field.
        mode       = MODE_DRAIN;
        words_made = 0;
        while (words_made < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                // Noise: unused codes, not counted as real traffic.
                queue_word($urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B,
                           $urandom, $urandom_range(0, 31));
                continue;
            end

            if (gen_len == CAPACITY && $urandom_range(0, 9) < 3)
                mode = MODE_DRAIN;
            else if (gen_len == 0 && $urandom_range(0, 9) < 3)
                mode = MODE_FILL;
            else if ($urandom_range(0, 99) < 3)
                mode = traffic_mode_t'($urandom_range(0, 2));

            val = ($urandom_range(0, 9) == 0) ?
                  (($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX) : $urandom;
            if ($urandom_range(0, 19) == 0)
                val = ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;

            ins_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_DRAIN) ? 20 : 50;
            if ($urandom_range(0, 99) < ins_pct)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    kind = REQ_INS_POS;
                    2:       kind = REQ_INS_FRONT;
                    default: kind = REQ_INS_END;
                endcase
                pos = ($urandom_range(0, 99) < 88) ? $urandom_range(0, gen_len)
                                                    : $urandom_range(0, 31);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0, 1:    kind = REQ_REM_POS;
                    2:       kind = REQ_REM_FRONT;
                    default: kind = REQ_REM_END;
                endcase
                pos = (gen_len > 0 && $urandom_range(0, 99) < 88) ?
                      $urandom_range(0, gen_len - 1) : $urandom_range(0, 31);
            end
            queue_word(kind, val, pos);
            words_made++;
        end

        // Wait until every word is taken and every response has come back.
        while (!(req_backlog_q.size() == 0 && pending_rsp_q.size() == 0) && !timed_out)
        begin
            @(negedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end

        if (timed_out)
        begin
            $display("%0t: watchdog expired after %0d idle cycles (%0d queued, %0d owed)",
                     $time, WATCHDOG_LIMIT, req_backlog_q.size(), pending_rsp_q.size());
            mismatch_count++;
        end
        else
        begin
            // Drop nothing: let a stray late response show up before the verdict.
            repeat (DRAIN_CYCLES) @(negedge clk);
        end

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/plb_pkg.sv
hw/rtl/plb_ctrl.sv
hw/rtl/plb_datapath.sv
hw/rtl/positional_list_buffer_top.sv
bench/tb_positional_list_buffer_top.sv
